// ----- hw/rtl/ica_pkg.sv -----
// ----------------------------------------------------------------------------
// ica_pkg: interval channel allocator package
// Sizes, row layout of the reservation memory, sequencer states and the
// result struct of the shared slot compare unit.
// ----------------------------------------------------------------------------
package ica_pkg;

    localparam int STATIONS = 4;
    localparam int CHANNELS = 256;
    localparam int SLOTS    = 4;

    localparam int STATION_W = 2;
    localparam int TIME_W    = 32;
    localparam int SUBBAND_W = 9;
    localparam int CHAN_W    = 8;

    localparam int ROWS   = STATIONS * CHANNELS;
    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CUR_W  = $clog2(CHANNELS + 1);
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef struct packed {
        logic [TIME_W-1:0]    start_time;
        logic [TIME_W-1:0]    stop_time;
        logic [SUBBAND_W-1:0] subband;
    } slot_t;

    typedef struct packed {
        logic [SLOTS-1:0] used;
        slot_t [SLOTS-1:0] slot;
    } row_t;

    typedef struct packed {
        logic overlap;
        logic expired;
    } cmp_res_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_WRITE,
        ST_RESP
    } state_t;

endpackage

// ----- hw/rtl/ica_stream_if.sv -----
// ----------------------------------------------------------------------------
// ica_stream_if: request and response channels
// Valid/ready channels; a transfer completes when valid and ready are high.
// ----------------------------------------------------------------------------
interface ica_req_if;
    logic                          valid;
    logic                          ready;
    logic [ica_pkg::STATION_W-1:0] station;
    logic [ica_pkg::TIME_W-1:0]    start_time;
    logic [ica_pkg::TIME_W-1:0]    stop_time;
    logic [ica_pkg::TIME_W-1:0]    now_time;
    logic [ica_pkg::SUBBAND_W-1:0] subband;
    logic                          first_of_request;
    logic                          last_of_request;

    modport source (
        output valid, station, start_time, stop_time, now_time, subband,
               first_of_request, last_of_request,
        input  ready
    );

    modport sink (
        input  valid, station, start_time, stop_time, now_time, subband,
               first_of_request, last_of_request,
        output ready
    );
endinterface

interface ica_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [ica_pkg::CHAN_W-1:0] channel;
    logic                       granted;
    logic                       request_ok;
    logic                       last;

    modport source (
        output valid, channel, granted, request_ok, last,
        input  ready
    );

    modport sink (
        input  valid, channel, granted, request_ok, last,
        output ready
    );
endinterface

// ----- hw/rtl/ica_slot_cmp.sv -----
// ----------------------------------------------------------------------------
// ica_slot_cmp: shared slot compare unit
// Tests one stored slot against the requested window and the current time.
// ----------------------------------------------------------------------------
module ica_slot_cmp (
    input  ica_pkg::slot_t              slot,
    input  logic [ica_pkg::TIME_W-1:0]  start_time,
    input  logic [ica_pkg::TIME_W-1:0]  stop_time,
    input  logic [ica_pkg::TIME_W-1:0]  now_time,
    output ica_pkg::cmp_res_t           res
);
    import ica_pkg::*;

    always_comb
    begin
        res.overlap = (start_time <= slot.stop_time) && (stop_time >= slot.start_time);
        res.expired = (slot.stop_time < now_time);
    end

endmodule

// ----- hw/rtl/interval_channel_allocator.sv -----
// ----------------------------------------------------------------------------
// interval_channel_allocator: per-station channel reservation
// Scans channels from a request cursor, freeing expired slots, until the first
// one not overlapping the window; reserves a free slot there, or fails.
// ----------------------------------------------------------------------------
// Each scanned channel takes a row read, one compare per slot in the shared
// compare unit and a row write; a refused item skips the scan and goes
// straight to the response register. A new item is taken only after the
// response of the last one is loaded into the output register.
// Reset: a clearing pass writes all 1024 (STATIONS * CHANNELS) rows
// with every slot free; no request is taken until it ends.
// ----------------------------------------------------------------------------
module interval_channel_allocator (
    input  logic      clk,
    input  logic      rst_n,
    ica_req_if.sink   req,
    ica_rsp_if.source rsp
);
    import ica_pkg::*;

    row_t mem [ROWS];
    row_t mem_rdata_reg;

    state_t               state_reg, state_next;
    logic [CUR_W-1:0]     cursor_reg, cursor_next;
    logic                 failed_reg, failed_next;
    logic [ROW_AW-1:0]    clr_addr_reg, clr_addr_next;
    logic [SLOT_W-1:0]    slot_idx_reg, slot_idx_next;
    logic                 blocked_reg, blocked_next;
    logic                 found_reg, found_next;
    logic [SLOT_W-1:0]    free_idx_reg, free_idx_next;
    logic [SLOTS-1:0]     used_new_reg, used_new_next;
    logic                 granted_reg, granted_next;
    logic [CHAN_W-1:0]    chan_reg, chan_next;

    logic [STATION_W-1:0] station_reg;
    logic [TIME_W-1:0]    start_reg;
    logic [TIME_W-1:0]    stop_reg;
    logic [TIME_W-1:0]    now_reg;
    logic [SUBBAND_W-1:0] subband_reg;
    logic                 last_reg;

    logic                 out_valid_reg, out_valid_next;
    logic [CHAN_W-1:0]    out_chan_reg, out_chan_next;
    logic                 out_granted_reg, out_granted_next;
    logic                 out_ok_reg, out_ok_next;
    logic                 out_last_reg, out_last_next;

    logic                 req_xfer;
    logic                 rd_en;
    logic [ROW_AW-1:0]    row_addr;
    logic                 wr_en;
    logic [ROW_AW-1:0]    wr_addr;
    row_t                 wr_row;
    slot_t                cur_slot;
    cmp_res_t             cmp_res;
    logic [CUR_W-1:0]     cursor_eff;
    logic                 failed_eff;
    logic [CUR_W-1:0]     cursor_inc;
    logic                 used_bit;
    logic                 keep_bit;

    assign req.ready = (state_reg == ST_IDLE);
    assign req_xfer  = req.valid && req.ready;

    assign rsp.valid      = out_valid_reg;
    assign rsp.channel    = out_chan_reg;
    assign rsp.granted    = out_granted_reg;
    assign rsp.request_ok = out_ok_reg;
    assign rsp.last       = out_last_reg;

    assign row_addr = ROW_AW'(ROW_AW'(station_reg) * ROW_AW'(CHANNELS) + ROW_AW'(cursor_reg));
    assign cur_slot = mem_rdata_reg.slot[slot_idx_reg];
    assign used_bit = mem_rdata_reg.used[slot_idx_reg];
    assign keep_bit = used_bit && !cmp_res.expired;
    assign cursor_inc = CUR_W'(cursor_reg + CUR_W'(1));
    assign cursor_eff = req.first_of_request ? '0 : cursor_reg;
    assign failed_eff = req.first_of_request ? 1'b0 : failed_reg;

    ica_slot_cmp u_slot_cmp (
        .slot       (cur_slot),
        .start_time (start_reg),
        .stop_time  (stop_reg),
        .now_time   (now_reg),
        .res        (cmp_res)
    );

    always_comb
    begin
        state_next       = state_reg;
        cursor_next      = cursor_reg;
        failed_next      = failed_reg;
        clr_addr_next    = clr_addr_reg;
        slot_idx_next    = slot_idx_reg;
        blocked_next     = blocked_reg;
        found_next       = found_reg;
        free_idx_next    = free_idx_reg;
        used_new_next    = used_new_reg;
        granted_next     = granted_reg;
        chan_next        = chan_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_chan_next    = out_chan_reg;
        out_granted_next = out_granted_reg;
        out_ok_next      = out_ok_reg;
        out_last_next    = out_last_reg;
        rd_en            = 1'b0;
        wr_en            = 1'b0;
        wr_addr          = row_addr;
        wr_row           = mem_rdata_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en         = 1'b1;
                wr_addr       = clr_addr_reg;
                wr_row        = '0;
                clr_addr_next = ROW_AW'(clr_addr_reg + ROW_AW'(1));
                if (clr_addr_reg == ROW_AW'(ROWS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    cursor_next  = cursor_eff;
                    failed_next  = failed_eff;
                    granted_next = 1'b0;
                    chan_next    = '0;
                    if (failed_eff)
                    begin
                        state_next = ST_RESP;
                    end
                    else if ((int'(req.station) >= STATIONS) ||
                             (cursor_eff == CUR_W'(CHANNELS)))
                    begin
                        failed_next = 1'b1;
                        state_next  = ST_RESP;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                rd_en         = 1'b1;
                slot_idx_next = '0;
                blocked_next  = 1'b0;
                found_next    = 1'b0;
                free_idx_next = '0;
                state_next    = ST_EVAL;
            end
            ST_EVAL:
            begin
                used_new_next[slot_idx_reg] = keep_bit;
                blocked_next = blocked_reg || (used_bit && cmp_res.overlap);
                if (!keep_bit && !found_reg)
                begin
                    found_next    = 1'b1;
                    free_idx_next = slot_idx_reg;
                end
                slot_idx_next = SLOT_W'(slot_idx_reg + SLOT_W'(1));
                if (slot_idx_reg == SLOT_W'(SLOTS - 1))
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                wr_en       = 1'b1;
                wr_row.used = used_new_reg;
                if (!blocked_reg && found_reg)
                begin
                    wr_row.used[free_idx_reg]            = 1'b1;
                    wr_row.slot[free_idx_reg].start_time = start_reg;
                    wr_row.slot[free_idx_reg].stop_time  = stop_reg;
                    wr_row.slot[free_idx_reg].subband    = subband_reg;
                end
                cursor_next = cursor_inc;
                if (!blocked_reg)
                begin
                    granted_next = found_reg;
                    chan_next    = CHAN_W'(cursor_reg);
                    if (!found_reg)
                    begin
                        failed_next = 1'b1;
                    end
                    state_next = ST_RESP;
                end
                else if (cursor_inc == CUR_W'(CHANNELS))
                begin
                    failed_next = 1'b1;
                    state_next  = ST_RESP;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_chan_next    = granted_reg ? chan_reg : '0;
                    out_granted_next = granted_reg;
                    out_ok_next      = !failed_reg;
                    out_last_next    = last_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cursor_reg    <= '0;
            failed_reg    <= 1'b0;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            failed_reg    <= failed_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_idx_reg    <= slot_idx_next;
        blocked_reg     <= blocked_next;
        found_reg       <= found_next;
        free_idx_reg    <= free_idx_next;
        used_new_reg    <= used_new_next;
        granted_reg     <= granted_next;
        chan_reg        <= chan_next;
        out_chan_reg    <= out_chan_next;
        out_granted_reg <= out_granted_next;
        out_ok_reg      <= out_ok_next;
        out_last_reg    <= out_last_next;
        if (req_xfer)
        begin
            station_reg <= req.station;
            start_reg   <= req.start_time;
            stop_reg    <= req.stop_time;
            now_reg     <= req.now_time;
            subband_reg <= req.subband;
            last_reg    <= req.last_of_request;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_row;
        end
        if (rd_en)
        begin
            mem_rdata_reg <= mem[row_addr];
        end
    end

endmodule

// ----- hw/rtl/ica_checker.sv -----
// ----------------------------------------------------------------------------
// ica_checker: port-level checks for the channel allocator
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module ica_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [7:0] rsp_channel,
    input logic       rsp_granted,
    input logic       rsp_request_ok
);

    // hold response until transfer
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped before transfer");

    a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_granted |-> rsp_request_ok)
        else $error("grant reported on a failed request");

    a_refused_chan: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_granted |-> rsp_channel == 8'd0)
        else $error("nonzero channel on a refused item");

    // one item in flight
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while an item is in flight");

endmodule

bind interval_channel_allocator ica_checker u_ica_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_channel    (rsp.channel),
    .rsp_granted    (rsp.granted),
    .rsp_request_ok (rsp.request_ok)
);
